// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Table geometry, field widths, request and result formats, operation,
// status and register codes, and the sequencer states.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_WIDTH = 32;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int LEN_W   = 24;
    localparam int RLEN_W  = LEN_W + 1;
    localparam int LIMIT_W = 25;
    localparam int HDR_W   = 7;
    localparam int ROOM_W  = (ADDR_WIDTH > RLEN_W + 1) ? ADDR_WIDTH : RLEN_W + 1;

    // first-hit encoder grouping
    localparam int GRP_W = 8;
    localparam int GRP_N = (MAX_BLOCKS + GRP_W - 1) / GRP_W;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int REG_W   = 2;

    localparam logic [REG_W-1:0] REG_HEAP_BASE    = 2'd0;
    localparam logic [REG_W-1:0] REG_HEAP_LIMIT   = 2'd1;
    localparam logic [REG_W-1:0] REG_HEADER_BYTES = 2'd2;

    localparam logic [31:0]        HEAP_BASE_RST = 32'h0040_0000;
    localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 25'h010_0000;
    localparam logic [HDR_W-1:0]   HEADER_RST     = 7'd12;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESIZE  = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NONE    = 2'd1,
        ST_SPACE   = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PRI1,
        S_PRI2,
        S_SEL,
        S_EXEC
    } state_e;

    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] request_size;
        logic [31:0] target_address;
    } ffba_req_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
    } ffba_rsp_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic valid;
        logic wr;
        logic set_free;
        logic clr_free;
    } ffba_cell_ctl_t;

    // request data broadcast to every cell
    typedef struct packed {
        logic [ADDR_WIDTH-1:0] target;
        logic [LEN_W-1:0]      size;
        logic [RLEN_W-1:0]     rlen;
        logic [ADDR_WIDTH-1:0] wr_start;
        logic [LEN_W-1:0]      wr_length;
    } ffba_bcast_t;

    // registered compare results of one cell
    typedef struct packed {
        logic match;
        logic fit;
        logic keep;
    } ffba_flags_t;

endpackage

// ===== src/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell: one entry of the block table
// Holds start address, rounded length and free mark of one block and
// registers its compare results against the request in flight.
// ----------------------------------------------------------------------------
module ffba_cell
    import ffba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffba_cell_ctl_t        ctl,
    input  ffba_bcast_t           bc,
    output ffba_flags_t           flags,
    output logic [ADDR_WIDTH-1:0] start
);

    logic [ADDR_WIDTH-1:0] start_reg;
    logic [LEN_W-1:0]      length_reg;
    logic                  free_reg;
    ffba_flags_t           flags_reg;
    ffba_flags_t           flags_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            start_reg  <= bc.wr_start;
            length_reg <= bc.wr_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= 1'b0;
        end
        else if (ctl.wr || ctl.clr_free)
        begin
            free_reg <= 1'b0;
        end
        else if (ctl.set_free)
        begin
            free_reg <= 1'b1;
        end
    end

    always_comb
    begin
        flags_next.match = ctl.valid && (start_reg == bc.target);
        flags_next.fit   = ctl.valid && free_reg && ({1'b0, length_reg} >= bc.rlen);
        flags_next.keep  = (length_reg >= bc.size);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;
    assign start = start_reg;

endmodule

// ===== src/ffba_first.sv =====
// ----------------------------------------------------------------------------
// ffba_first: two-stage first-hit encoder
// Picks the lowest set bit of the cell hit vector: first within groups of
// eight, then across groups, with a register after each level.
// ----------------------------------------------------------------------------
module ffba_first
    import ffba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [MAX_BLOCKS-1:0] hits,
    output logic [MAX_BLOCKS-1:0] first_oh,
    output logic                  any
);

    logic [GRP_N*GRP_W-1:0]       hits_pad;
    logic [GRP_N-1:0][GRP_W-1:0]  grp_first_reg;
    logic [GRP_N-1:0][GRP_W-1:0]  grp_first_next;
    logic [GRP_N-1:0]             grp_any_reg;
    logic [GRP_N-1:0]             grp_any_next;
    logic [GRP_N*GRP_W-1:0]       oh_full;
    logic [MAX_BLOCKS-1:0]        first_oh_reg;
    logic                         any_reg;

    assign hits_pad = (GRP_N * GRP_W)'(hits);

    always_comb
    begin
        logic seen;
        for (int g = 0; g < GRP_N; g++)
        begin
            seen = 1'b0;
            for (int j = 0; j < GRP_W; j++)
            begin
                grp_first_next[g][j] = hits_pad[g*GRP_W + j] && !seen;
                seen = seen || hits_pad[g*GRP_W + j];
            end
            grp_any_next[g] = seen;
        end
    end

    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int g = 0; g < GRP_N; g++)
        begin
            for (int j = 0; j < GRP_W; j++)
            begin
                oh_full[g*GRP_W + j] = grp_first_reg[g][j] && grp_any_reg[g] && !seen;
            end
            seen = seen || grp_any_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_first_reg <= '0;
            grp_any_reg   <= '0;
            first_oh_reg  <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            grp_first_reg <= grp_first_next;
            grp_any_reg   <= grp_any_next;
            first_oh_reg  <= oh_full[MAX_BLOCKS-1:0];
            any_reg       <= |grp_any_reg;
        end
    end

    assign first_oh = first_oh_reg;
    assign any      = any_reg;

endmodule

// ===== src/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap block allocator
// Block table held in a row of cells; allocate, release and resize requests
// resolved by parallel compare and a first-hit encoder, no coalescing.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  -------------------------
//  request   in         start high, busy low    request (ffba_req_t)
//  result    out        done strobe, one cycle  result  (ffba_rsp_t)
//  config    in/out     APB, pready tied high   heap_base/limit/header
//
//  Each request passes through the cell compare, two levels of the first-hit
//  encoder, selection of the winning entry and the table update; busy stays
//  high until the update is done. The result strobe comes in the cycle
//  after the update, while busy is already low, so a new request may be
//  accepted in that same cycle. Reset clears the free marks, the block count
//  and the sequencer and loads the register defaults; start address and
//  length of an entry hold no value until the entry is appended. The result
//  receiver cannot stall: take the result while done is high.
//
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  ffba_req_t          request,
    // result channel
    output logic               done,
    output ffba_rsp_t          result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ADDR_WIDTH-1:0] heap_base_reg;
    logic [LIMIT_W-1:0]    heap_limit_reg;
    logic [HDR_W-1:0]      header_reg;
    logic                  cfg_wr;

    // ------------------------------------------------------------------
    // Table bookkeeping and sequencer
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      block_count_reg;
    logic [ADDR_WIDTH-1:0] heap_top_reg;
    state_e                state_reg;
    state_e                state_next;

    // latched request
    logic [1:0]            op_reg;
    logic [LEN_W-1:0]      size_reg;
    logic [ADDR_WIDTH-1:0] target_reg;
    logic [RLEN_W-1:0]     rlen;

    // append path
    logic [ADDR_WIDTH-1:0] used_reg;
    logic [ADDR_WIDTH-1:0] user_reg;
    logic [ADDR_WIDTH-1:0] new_top_reg;
    logic                  room_ok_reg;

    // cell row
    ffba_bcast_t           bc;
    ffba_cell_ctl_t        cell_ctl   [MAX_BLOCKS];
    ffba_flags_t           cell_flags [MAX_BLOCKS];
    logic [ADDR_WIDTH-1:0] cell_start [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] match_vec;
    logic [MAX_BLOCKS-1:0] fit_vec;
    logic [MAX_BLOCKS-1:0] keep_vec;
    logic [MAX_BLOCKS-1:0] match_oh;
    logic [MAX_BLOCKS-1:0] fit_oh;
    logic                  match_any;
    logic                  fit_any;

    // selected entry
    logic                  keep_sel_reg;
    logic [ADDR_WIDTH-1:0] fit_start_reg;
    logic [ADDR_WIDTH-1:0] fit_start_or;

    // update decision
    logic                  exec;
    logic [1:0]            st_alloc;
    logic [ADDR_WIDTH-1:0] addr_alloc;
    logic                  claim_alloc;
    logic                  append_alloc;
    logic [1:0]            st_exec;
    logic [ADDR_WIDTH-1:0] addr_exec;
    logic                  claim_exec;
    logic                  append_exec;
    logic                  set_exec;

    // result
    logic                  done_reg;
    ffba_rsp_t             result_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= ADDR_WIDTH'(HEAP_BASE_RST);
            heap_limit_reg <= HEAP_LIMIT_RST;
            header_reg     <= HEADER_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[PADDR_W-1:2])
                REG_HEAP_BASE:    heap_base_reg  <= ADDR_WIDTH'(pwdata);
                REG_HEAP_LIMIT:   heap_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_HEADER_BYTES: header_reg     <= pwdata[HDR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1:2])
            REG_HEAP_BASE:    prdata = 32'(heap_base_reg);
            REG_HEAP_LIMIT:   prdata = 32'(heap_limit_reg);
            REG_HEADER_BYTES: prdata = 32'(header_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        exec       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:  state_next = S_PRI1;
            S_PRI1: state_next = S_PRI2;
            S_PRI2: state_next = S_SEL;
            S_SEL:  state_next = S_EXEC;
            S_EXEC:
            begin
                exec       = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the request for the whole pass through the cells
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg     <= request.op;
            size_reg   <= request.request_size;
            target_reg <= ADDR_WIDTH'(request.target_address);
        end
    end

    // Round the length up to a whole word; bit 24 set means oversize
    assign rlen = (RLEN_W'(size_reg) + RLEN_W'(3)) & ~RLEN_W'(3);

    // ------------------------------------------------------------------
    // Append path: used heap, room check and the new block's addresses.
    // These follow the held request and settle well before the update.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        used_reg    <= heap_top_reg - heap_base_reg;
        user_reg    <= heap_top_reg + ADDR_WIDTH'(header_reg);
        new_top_reg <= heap_top_reg + ADDR_WIDTH'(header_reg) + ADDR_WIDTH'(rlen);
        room_ok_reg <= (ROOM_W'(used_reg) <= ROOM_W'(heap_limit_reg))
                    && (ROOM_W'(header_reg) + ROOM_W'(rlen)
                        <= ROOM_W'(heap_limit_reg) - ROOM_W'(used_reg));
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    always_comb
    begin
        bc.target    = target_reg;
        bc.size      = size_reg;
        bc.rlen      = rlen;
        bc.wr_start  = user_reg;
        bc.wr_length = rlen[LEN_W-1:0];
    end

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctl[i].valid    = (CNT_W'(i) < block_count_reg);
            cell_ctl[i].wr       = exec && append_exec && (block_count_reg == CNT_W'(i));
            cell_ctl[i].set_free = exec && set_exec && match_oh[i];
            cell_ctl[i].clr_free = exec && claim_exec && fit_oh[i];
        end

        ffba_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl[i]),
            .bc    (bc),
            .flags (cell_flags[i]),
            .start (cell_start[i])
        );

        assign match_vec[i] = cell_flags[i].match;
        assign fit_vec[i]   = cell_flags[i].fit;
        assign keep_vec[i]  = cell_flags[i].keep;
    end

    // first entry holding the target address
    ffba_first u_first_match
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .hits     (match_vec),
        .first_oh (match_oh),
        .any      (match_any)
    );

    // first free entry large enough
    ffba_first u_first_fit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .hits     (fit_vec),
        .first_oh (fit_oh),
        .any      (fit_any)
    );

    always_comb
    begin
        fit_start_or = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            fit_start_or = fit_start_or | (cell_start[i] & {ADDR_WIDTH{fit_oh[i]}});
        end
    end

    always_ff @(posedge clk)
    begin
        keep_sel_reg  <= |(keep_vec & match_oh);
        fit_start_reg <= fit_start_or;
    end

    // ------------------------------------------------------------------
    // Update decision
    // ------------------------------------------------------------------
    // allocate: reuse the first fitting free block, else append at the top
    always_comb
    begin
        st_alloc     = ST_DONE;
        addr_alloc   = '0;
        claim_alloc  = 1'b0;
        append_alloc = 1'b0;
        priority if (size_reg == '0)
        begin
            st_alloc = ST_NONE;
        end
        else if (rlen[RLEN_W-1])
        begin
            st_alloc = ST_SPACE;
        end
        else if (fit_any)
        begin
            addr_alloc  = fit_start_reg;
            claim_alloc = 1'b1;
        end
        else if (block_count_reg >= CNT_W'(MAX_BLOCKS))
        begin
            st_alloc = ST_SPACE;
        end
        else if (!room_ok_reg || (user_reg == '0))
        begin
            st_alloc = ST_SPACE;
        end
        else
        begin
            addr_alloc   = user_reg;
            append_alloc = 1'b1;
        end
    end

    always_comb
    begin
        st_exec     = ST_NONE;
        addr_exec   = '0;
        claim_exec  = 1'b0;
        append_exec = 1'b0;
        set_exec    = 1'b0;
        case (op_reg)
            OP_ALLOC:
            begin
                st_exec     = st_alloc;
                addr_exec   = addr_alloc;
                claim_exec  = claim_alloc;
                append_exec = append_alloc;
            end
            OP_RELEASE:
            begin
                priority if (target_reg == '0)
                begin
                    st_exec = ST_NONE;
                end
                else if (!match_any)
                begin
                    st_exec = ST_UNKNOWN;
                end
                else
                begin
                    st_exec  = ST_DONE;
                    set_exec = 1'b1;
                end
            end
            OP_RESIZE:
            begin
                priority if (target_reg == '0)
                begin
                    st_exec     = st_alloc;
                    addr_exec   = addr_alloc;
                    claim_exec  = claim_alloc;
                    append_exec = append_alloc;
                end
                else if (!match_any)
                begin
                    st_exec = ST_UNKNOWN;
                end
                else if (size_reg == '0)
                begin
                    st_exec  = ST_DONE;
                    set_exec = 1'b1;
                end
                else if (keep_sel_reg)
                begin
                    st_exec   = ST_DONE;
                    addr_exec = target_reg;
                end
                else
                begin
                    // grow: take a new block, free the old one only on success
                    st_exec     = st_alloc;
                    addr_exec   = addr_alloc;
                    claim_exec  = claim_alloc;
                    append_exec = append_alloc;
                    set_exec    = (st_alloc == ST_DONE);
                end
            end
            default:
            begin
                st_exec = ST_NONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Block count and heap top
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
            heap_top_reg    <= ADDR_WIDTH'(HEAP_BASE_RST);
        end
        else if (exec && append_exec)
        begin
            block_count_reg <= block_count_reg + CNT_W'(1);
            heap_top_reg    <= new_top_reg;
        end
        else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_HEAP_BASE)
                 && (block_count_reg == '0))
        begin
            // an empty table follows the new base
            heap_top_reg <= ADDR_WIDTH'(pwdata);
        end
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            result_reg.result_address <= 32'(addr_exec);
            result_reg.status         <= st_exec;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without a table update");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        block_count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table size");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_oh) && $onehot0(fit_oh))
        else $error("first-hit encoder selected more than one entry");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CMP))
        else $error("accepted request did not start a pass");
`endif

endmodule
